@@ rtl/merge_sort_engine_core_macros.svh @@
// Assertion macros for the merge sort engine checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef MERGE_SORT_ENGINE_CORE_MACROS_SVH
`define MERGE_SORT_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mse_pkg.sv @@
// Shared types and constants for the merge sort engine.
// No dependencies; imported by every module of the block but the checker.
`timescale 1ns / 1ps

package mse_pkg;

  localparam int MSE_MAX_ELEMENTS = 64;
  localparam int MSE_VALUE_BITS   = 32;
  localparam int MSE_IO_BITS      = 32;

  // Source of the data written into a buffer.
  typedef enum logic [1:0] {
    WR_SRC_IN,
    WR_SRC_P,
    WR_SRC_Q
  } mse_wr_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        wr_a;
    logic        wr_b;
    mse_wr_src_t wr_src;
    logic        rd_en;
    logic        rd_sel_b;
    logic        out_rd;
    logic        out_final;
    logic        out_ovf;
  } mse_cmd_t;

endpackage

@@ rtl/merge_sort_engine_core.sv @@
// Merge sort engine. Load: one request per cycle while busy is low; a set with n
// stored values then sorts in ceil(log2 n) bottom-up passes, each element of a pass
// taking a registered two-port buffer read, then a compare and write, with a setup
// state per run and per pass; readout then strobes one value per cycle, n values.
// Reset (rst_n low, synchronous) empties the set and clears busy and the strobe.
`timescale 1ns / 1ps

module merge_sort_engine_core
  import mse_pkg::*;
#(
  parameter int MAX_ELEMENTS = MSE_MAX_ELEMENTS,
  parameter int VALUE_BITS   = MSE_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel: taken when start is high and busy is low
  input  logic                          start,
  output logic                          busy,
  input  logic signed [MSE_IO_BITS-1:0] in_value,
  input  logic                          in_last,
  // result channel: one strobe per sorted value, cannot be held off
  output logic                          out_valid,
  output logic signed [MSE_IO_BITS-1:0] out_sorted_value,
  output logic                          out_final_res,
  output logic                          out_overflow
);

  localparam int AW = $clog2(MAX_ELEMENTS);

  mse_cmd_t      cmd;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr_p;
  logic [AW-1:0] rd_addr_q;
  logic          p_less;

  // Controller: counts stored values, walks runs and passes, sequences readout.
  mse_ctrl #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_last  (in_last),
    .p_less   (p_less),
    .busy     (busy),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr_p(rd_addr_p),
    .rd_addr_q(rd_addr_q)
  );

  // Datapath: two buffers that swap roles every pass, the compare that
  // picks the next merged value (right run wins ties), and the result register.
  mse_datapath #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .wr_addr         (wr_addr),
    .rd_addr_p       (rd_addr_p),
    .rd_addr_q       (rd_addr_q),
    .in_value        (in_value),
    .p_less          (p_less),
    .out_valid       (out_valid),
    .out_sorted_value(out_sorted_value),
    .out_final_res   (out_final_res),
    .out_overflow    (out_overflow)
  );

endmodule

@@ rtl/mse_ctrl.sv @@
// Sequencer of the merge sort engine: load, merge passes and readout.
// Uses mse_pkg; drives the buffer addresses and commands of mse_datapath.
`timescale 1ns / 1ps

module mse_ctrl
  import mse_pkg::*;
#(
  parameter int MAX_ELEMENTS = MSE_MAX_ELEMENTS,
  localparam int AW = $clog2(MAX_ELEMENTS),
  localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_last,
  input  logic          p_less,
  output logic          busy,
  output mse_cmd_t      cmd,
  output logic [AW-1:0] wr_addr,
  output logic [AW-1:0] rd_addr_p,
  output logic [AW-1:0] rd_addr_q
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_RUN,
    S_READ,
    S_MERGE,
    S_OUT
  } state_t;

  localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);
  localparam logic [CW:0]   ONE_X = (CW + 1)'(1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic [CW:0]   w_r, w_nxt;
  logic          in_a_r, in_a_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [CW-1:0] q_r, q_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] i_r, i_nxt;

  logic [CW:0] cnt_x;
  logic [CW:0] sum_mid;
  logic [CW:0] sum_hi;
  logic        take_p;
  logic        k_end;
  logic        i_end;

  assign busy    = (state_r != S_IDLE);
  assign cnt_x   = {1'b0, cnt_r};
  assign sum_mid = {1'b0, lo_r} + w_r;
  assign sum_hi  = {1'b0, lo_r} + {w_r[CW-1:0], 1'b0};
  assign take_p  = (p_r < mid_r) && ((q_r >= hi_r) || p_less);
  assign k_end   = (({1'b0, k_r} + ONE_X) == {1'b0, hi_r});
  assign i_end   = (({1'b0, i_r} + ONE_X) == cnt_x);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    w_nxt     = w_r;
    in_a_nxt  = in_a_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    cmd       = '0;
    cmd.wr_src = WR_SRC_IN;
    wr_addr   = cnt_r[AW-1:0];
    rd_addr_p = p_r[AW-1:0];
    rd_addr_q = q_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (cnt_r < MAX_C) begin
            cmd.wr_a = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            w_nxt     = ONE_X;
            in_a_nxt  = 1'b1;
            state_nxt = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (w_r < cnt_x) begin
          lo_nxt    = '0;
          state_nxt = S_RUN;
        end else begin
          i_nxt     = '0;
          state_nxt = S_OUT;
        end
      end
      S_RUN: begin
        mid_nxt   = (sum_mid > cnt_x) ? cnt_r : sum_mid[CW-1:0];
        hi_nxt    = (sum_hi > cnt_x) ? cnt_r : sum_hi[CW-1:0];
        p_nxt     = lo_r;
        q_nxt     = (sum_mid > cnt_x) ? cnt_r : sum_mid[CW-1:0];
        k_nxt     = lo_r;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel_b = !in_a_r;
        state_nxt    = S_MERGE;
      end
      S_MERGE: begin
        cmd.wr_a   = !in_a_r;
        cmd.wr_b   = in_a_r;
        cmd.wr_src = take_p ? WR_SRC_P : WR_SRC_Q;
        wr_addr    = k_r[AW-1:0];
        k_nxt      = k_r + 1'b1;
        if (take_p) begin
          p_nxt = p_r + 1'b1;
        end else begin
          q_nxt = q_r + 1'b1;
        end
        if (!k_end) begin
          state_nxt = S_READ;
        end else if (hi_r == cnt_r) begin
          in_a_nxt  = !in_a_r;
          w_nxt     = {w_r[CW-1:0], 1'b0};
          state_nxt = S_PASS;
        end else begin
          lo_nxt    = hi_r;
          state_nxt = S_RUN;
        end
      end
      S_OUT: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel_b  = !in_a_r;
        cmd.out_rd    = 1'b1;
        cmd.out_final = i_end;
        cmd.out_ovf   = drop_r;
        rd_addr_p     = i_r[AW-1:0];
        i_nxt         = i_r + 1'b1;
        if (i_end) begin
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      w_r     <= ONE_X;
      in_a_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      w_r     <= w_nxt;
      in_a_r  <= in_a_nxt;
    end
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
    p_r   <= p_nxt;
    q_r   <= q_nxt;
    k_r   <= k_nxt;
    i_r   <= i_nxt;
  end

endmodule

@@ rtl/mse_datapath.sv @@
// Datapath of the merge sort engine: ping-pong buffers, compare, result register.
// Uses mse_pkg; commanded by mse_ctrl.
`timescale 1ns / 1ps

module mse_datapath
  import mse_pkg::*;
#(
  parameter int MAX_ELEMENTS = MSE_MAX_ELEMENTS,
  parameter int VALUE_BITS   = MSE_VALUE_BITS,
  localparam int AW = $clog2(MAX_ELEMENTS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mse_cmd_t                      cmd,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [AW-1:0]                 rd_addr_p,
  input  logic [AW-1:0]                 rd_addr_q,
  input  logic signed [MSE_IO_BITS-1:0] in_value,
  output logic                          p_less,
  output logic                          out_valid,
  output logic signed [MSE_IO_BITS-1:0] out_sorted_value,
  output logic                          out_final_res,
  output logic                          out_overflow
);

  logic [VALUE_BITS-1:0] mem_a [MAX_ELEMENTS];
  logic [VALUE_BITS-1:0] mem_b [MAX_ELEMENTS];
  logic [VALUE_BITS-1:0] rd_p_r;
  logic [VALUE_BITS-1:0] rd_q_r;
  logic [VALUE_BITS-1:0] in_ext;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  out_valid_r;
  logic                  final_r;
  logic                  ovf_r;

  generate
    if (VALUE_BITS > MSE_IO_BITS) begin : g_in_wide
      assign in_ext = {{(VALUE_BITS - MSE_IO_BITS){in_value[MSE_IO_BITS-1]}}, in_value};
    end else if (VALUE_BITS == MSE_IO_BITS) begin : g_in_same
      assign in_ext = in_value;
    end else begin : g_in_narrow
      assign in_ext = in_value[VALUE_BITS-1:0];
    end
    if (VALUE_BITS >= MSE_IO_BITS) begin : g_out_wide
      assign out_sorted_value = rd_p_r[MSE_IO_BITS-1:0];
    end else begin : g_out_narrow
      assign out_sorted_value = {{(MSE_IO_BITS - VALUE_BITS){1'b0}}, rd_p_r};
    end
  endgenerate

  assign p_less = ($signed(rd_p_r) < $signed(rd_q_r));

  always_comb begin
    case (cmd.wr_src)
      WR_SRC_IN: wr_data = in_ext;
      WR_SRC_P:  wr_data = rd_p_r;
      WR_SRC_Q:  wr_data = rd_q_r;
      default:   wr_data = in_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      mem_b[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_p_r <= cmd.rd_sel_b ? mem_b[rd_addr_p] : mem_a[rd_addr_p];
      rd_q_r <= cmd.rd_sel_b ? mem_b[rd_addr_q] : mem_a[rd_addr_q];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_rd;
    end
    final_r <= cmd.out_final;
    ovf_r   <= cmd.out_ovf;
  end

  assign out_valid     = out_valid_r;
  assign out_final_res = final_r;
  assign out_overflow  = ovf_r;

endmodule

@@ rtl/mse_checker.sv @@
// Port-level checks of the merge sort engine, bound to the top level.
// Uses the assertion macros of merge_sort_engine_core_macros.svh.
`timescale 1ns / 1ps
`include "merge_sort_engine_core_macros.svh"

module mse_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last,
  input logic out_valid,
  input logic out_final_res
);

  `MSE_ASSERT_NXT(a_idle_no_strobe, !busy, !out_valid, "result strobe without preceding sort")
  `MSE_ASSERT_NXT(a_mid_set_idle, start && !busy && !in_last, !busy, "busy after a non-last request")
  `MSE_ASSERT_NXT(a_last_busy, start && !busy && in_last, busy, "last request did not start the sort")
  `MSE_ASSERT_NXT(a_burst_unbroken, out_valid && !out_final_res, out_valid, "gap in the result burst")
  `MSE_ASSERT_NXT(a_final_ends, out_valid && out_final_res, !out_valid, "strobe after final result")

endmodule

bind merge_sort_engine_core mse_checker u_mse_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_last      (in_last),
  .out_valid    (out_valid),
  .out_final_res(out_final_res)
);

@@ test/mse_sort_scoreboard_pkg.sv @@
// Scoreboard for the merge sort engine testbench: collects each accepted set and checks
// the sorted readout field by field. Depends on mse_pkg for the buffer depth and widths.
`timescale 1ns / 1ps

package mse_sort_scoreboard_pkg;
  import mse_pkg::*;

  typedef logic signed [MSE_IO_BITS-1:0] io_word_t;

  typedef struct packed {
    io_word_t value;
    logic     final_res;
    logic     overflow;
  } sorted_item_t;

  class sort_scoreboard;
    io_word_t     stored_set[$];
    bit           set_dropped;
    sorted_item_t sorted_due[$];
    int unsigned  errors;

    function new();
      set_dropped = 1'b0;
      errors      = 0;
    endfunction

    // Hold the value if there is room; on the last mark, sort and queue the readout.
    function void note_request(io_word_t value, logic last);
      io_word_t     ordered[$];
      io_word_t     key;
      sorted_item_t item;
      int           i;
      int           j;
      if (stored_set.size() < MSE_MAX_ELEMENTS) stored_set.push_back(value);
      else set_dropped = 1'b1;
      if (!last) return;
      ordered = stored_set;
      for (i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j = i;
        while (j > 0 && ordered[j-1] > key) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = key;
      end
      for (i = 0; i < ordered.size(); i++) begin
        item.value     = ordered[i];
        item.final_res = (i == ordered.size() - 1);
        item.overflow  = set_dropped;
        sorted_due.push_back(item);
      end
      stored_set.delete();
      set_dropped = 1'b0;
    endfunction

    function void check_result(io_word_t value, logic final_res, logic overflow);
      sorted_item_t due;
      if (sorted_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d final_res=%b overflow=%b",
                 $time, value, final_res, overflow);
        return;
      end
      due = sorted_due.pop_front();
      if (value !== due.value || final_res !== due.final_res || overflow !== due.overflow) begin
        errors++;
        $display("%0t: mismatch expected value=%0d final_res=%b overflow=%b, got value=%0d final_res=%b overflow=%b",
                 $time, due.value, due.final_res, due.overflow, value, final_res, overflow);
      end
    endfunction

    function int unsigned outstanding();
      return sorted_due.size();
    endfunction
  endclass

endpackage

@@ test/tb_merge_sort_engine_core.sv @@
// Top-level testbench for merge_sort_engine_core: directed and random sets of signed values,
// bursty request traffic, readout checked against a sorting scoreboard.
// Depends on mse_pkg and mse_sort_scoreboard_pkg.
`timescale 1ns / 1ps

module tb_merge_sort_engine_core;
  import mse_pkg::*;
  import mse_sort_scoreboard_pkg::*;

  localparam int unsigned TARGET_ITEMS = 230;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  io_word_t in_value = '0;
  logic     in_last = 1'b0;
  logic     busy;
  logic     out_valid;
  io_word_t out_sorted_value;
  logic     out_final_res;
  logic     out_overflow;

  sort_scoreboard sb = new();

  int unsigned items_sent = 0;
  int unsigned burst_left = 1;

  merge_sort_engine_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflow     (out_overflow)
  );

  // 8 ns clock: rising edges at 4, 12, 20, ...; stimulus moves on falling edges.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watch both channels at the rising edge. Check results before noting a request so
  // that a readout strobe and a new request in the same cycle stay in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_sorted_value, out_final_res, out_overflow);
      if (start && !busy) sb.note_request(in_value, in_last);
    end
  end

  // Pick a burst length: mostly short bursts, sometimes long stretches without gaps.
  function automatic int unsigned next_burst();
    if ($urandom_range(0, 3) == 0) return $urandom_range(20, 70);
    return $urandom_range(1, 8);
  endfunction

  // Draw one element. Mode 0: any value; mode 1: a narrow band around zero so that
  // duplicates are common; mode 2: extremes, zero and their neighbors.
  function automatic io_word_t pick_value(int mode);
    io_word_t corner;
    case (mode)
      1: begin
        return io_word_t'($urandom_range(0, 8)) - io_word_t'(4);
      end
      2: begin
        case ($urandom_range(0, 6))
          0: corner = 32'sh8000_0000;
          1: corner = 32'sh8000_0001;
          2: corner = 32'sh7fff_ffff;
          3: corner = 32'sh7fff_fffe;
          4: corner = 32'sh0000_0000;
          5: corner = -32'sd1;
          default: corner = 32'sd1;
        endcase
        return corner;
      end
      default: begin
        return io_word_t'($urandom());
      end
    endcase
  endfunction

  // Present one request at the falling edge and hold it until accepted. Keep start high
  // inside a burst; at the end of a burst drop it and scribble over the payload for a gap.
  task automatic send_request(input io_word_t value, input logic last);
    int unsigned gap;
    start    <= 1'b1;
    in_value <= value;
    in_last  <= last;
    do @(posedge clk); while (busy);
    items_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left == 0) begin
      start    <= 1'b0;
      in_value <= io_word_t'($urandom());
      in_last  <= 1'($urandom_range(0, 1));
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
      burst_left = next_burst();
    end
  endtask

  task automatic send_values(input io_word_t vals[$]);
    for (int i = 0; i < vals.size(); i++) send_request(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_set(input int unsigned count, input int mode);
    for (int unsigned i = 0; i < count; i++) send_request(pick_value(mode), i == count - 1);
  endtask

  initial begin
    io_word_t    vals[$];
    int unsigned set_size;
    // Hold reset low from time zero, then release it on a falling edge.
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    burst_left = next_burst();

    // Single-element sets at both extremes.
    vals = '{32'sh8000_0000};
    send_values(vals);
    vals = '{32'sh7fff_ffff};
    send_values(vals);
    // Two elements, largest first.
    vals = '{32'sh7fff_ffff, 32'sh8000_0000};
    send_values(vals);
    // Duplicates around zero, including equal values in both runs of a merge.
    vals = '{32'sd0, -32'sd1, 32'sd1, -32'sd1, 32'sd0};
    send_values(vals);
    // Strictly descending, then all equal, then already sorted.
    vals = '{32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1, 32'sd0};
    send_values(vals);
    vals = '{-32'sd2, -32'sd2, -32'sd2};
    send_values(vals);
    vals = '{32'sh8000_0001, -32'sd7, 32'sd9, 32'sh7fff_fffe};
    send_values(vals);

    // Exactly a full buffer, then a set that runs past it so the tail, the last-marked
    // request included, is dropped and every result carries the overflow flag.
    send_random_set(MSE_MAX_ELEMENTS, 0);
    send_random_set(MSE_MAX_ELEMENTS + $urandom_range(1, 4), $urandom_range(0, 2));

    // Mostly small sets with random content until the item budget is used up.
    while (items_sent < TARGET_ITEMS) begin
      set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_random_set(set_size, $urandom_range(0, 2));
    end

    start <= 1'b0;
    // Drain the readout, then give the block a little time to show any stray strobe.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mse_pkg.sv
rtl/mse_ctrl.sv
rtl/mse_datapath.sv
rtl/merge_sort_engine_core.sv
rtl/mse_checker.sv
test/mse_sort_scoreboard_pkg.sv
test/tb_merge_sort_engine_core.sv
